// ----- rtl/min_coin_change_dp_defines.svh -----
// Assertion macros shared by the checker of min_coin_change_dp.
// No dependencies; include by bare file name.
`ifndef MIN_COIN_CHANGE_DP_DEFINES_SVH
`define MIN_COIN_CHANGE_DP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MCCD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("min_coin_change_dp: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define MCCD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("min_coin_change_dp: check failed");

`endif

// ----- rtl/mccd_pkg.sv -----
// Types and fixed constants for the minimum coin change block.
// No dependencies.
package mccd_pkg;

  localparam int COIN_W     = 10;
  localparam int COUNT_W    = 10;
  localparam int TARGET_MAX = 1023;

  // One table entry: reach flag and fewest coin count.
  typedef struct packed {
    logic               reach;
    logic [COUNT_W-1:0] count;
  } tbl_entry_t;

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_INIT = 5'b00010,
    S_SCAN = 5'b00100,
    S_WAIT = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

endpackage

// ----- rtl/mccd_table.sv -----
// Best-count table: one write port, one read port, registered read data.
// Depends on mccd_pkg for the entry type.
module mccd_table #(
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  mccd_pkg::tbl_entry_t wdata,
  input  logic [AW-1:0]       raddr,
  output mccd_pkg::tbl_entry_t rdata
);
  import mccd_pkg::*;

  tbl_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/min_coin_change_dp.sv -----
// Minimum coin change block: top level with coin store and table sequencer.
// Depends on mccd_pkg and mccd_table.
//
// Usage: feed coin denominations on the input channel, one transaction per
// cycle while the block is loading. A transaction with in_coin_valid set
// and a nonzero value stores a coin; coins past MAX_COINS are dropped and
// flagged. A transaction with in_last_item set (its own coin is stored
// first) ends the list and starts the table fill up to in_target_amount.
// in_stall stays high from then until the answer has been moved into the
// output register. The answer is one out_ transaction.
// A target of zero, a target above MAX_AMOUNT or an empty coin list is
// answered without a table fill. Otherwise the fill writes entry 0, then
// for each amount up to the target reads every stored coin from the coin
// store, drains the coin/table read pipeline and does one write of the
// table entry; set-up and the output load come before and after the fill.
// Coin loads run at one transaction per cycle.
// Reset (synchronous, rst_n low) empties the coin list and the output
// register; the table needs no clearing since every entry used is written
// before it is read. While out_stall holds, the result waits in the output
// register and a new coin list may already be loaded; a second answer
// waits in the sequencer until the first is taken.
module min_coin_change_dp #(
  parameter int MAX_AMOUNT = 1023,
  parameter int MAX_COINS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [9:0] in_coin_value,
  input  logic       in_coin_valid,
  input  logic [9:0] in_target_amount,
  input  logic       in_last_item,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [9:0] out_min_coins,
  output logic       out_unreachable,
  output logic       out_coins_dropped
);
  import mccd_pkg::*;

  localparam int TDEPTH = ((MAX_AMOUNT < TARGET_MAX) ? MAX_AMOUNT : TARGET_MAX) + 1;
  localparam int AW     = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int KW     = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam int CW     = $clog2(MAX_COINS + 1);

  state_t state_r, state_nxt;

  logic [CW-1:0]      coin_count_r, coin_count_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [COIN_W-1:0]  target_r, target_nxt;
  logic [COIN_W-1:0]  amt_r, amt_nxt;
  logic               found_r, found_nxt;
  logic [COUNT_W-1:0] best_r, best_nxt;
  logic               rd1_v_r, rd1_v_nxt;
  logic               rd2_v_r, rd2_v_nxt;
  logic [COUNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic               res_unr_r, res_unr_nxt;
  logic               res_drop_r, res_drop_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_cnt_r;
  logic               out_unr_r, out_drop_r;

  logic [COIN_W-1:0]  coin_mem [MAX_COINS];
  logic [COIN_W-1:0]  coin_q_r;

  logic               in_fire, take, room, coin_we;
  logic [CW-1:0]      cnt_after;
  logic               ovf_after;
  logic               drained, out_load;
  logic [COIN_W-1:0]  diff;
  logic [COUNT_W-1:0] best_inc;

  logic               tbl_we;
  logic [AW-1:0]      tbl_waddr, tbl_raddr;
  tbl_entry_t         tbl_wdata, tbl_q;

  assign in_stall  = (state_r != S_LOAD);
  assign in_fire   = in_valid & ~in_stall;
  assign take      = in_fire & in_coin_valid & (in_coin_value != '0);
  assign room      = (coin_count_r < CW'(MAX_COINS));
  assign coin_we   = take & room;
  assign cnt_after = coin_count_r + (coin_we ? CW'(1) : CW'(0));
  assign ovf_after = ovf_r | (take & ~room);
  assign drained   = ~rd1_v_r & ~rd2_v_r;
  assign out_load  = (state_r == S_OUT) & (~out_valid_r | ~out_stall);
  assign diff      = amt_r - coin_q_r;
  assign best_inc  = best_r + COUNT_W'(1);

  // Coin store: write on load, read at the scan index every cycle.
  always_ff @(posedge clk) begin
    if (coin_we) begin
      coin_mem[coin_count_r[KW-1:0]] <= in_coin_value;
    end
    coin_q_r <= coin_mem[k_r];
  end

  mccd_table #(
    .DEPTH (TDEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_q)
  );

  always_comb begin
    tbl_we          = 1'b0;
    tbl_waddr       = amt_r[AW-1:0];
    tbl_wdata.reach = found_r;
    tbl_wdata.count = found_r ? best_inc : '0;
    tbl_raddr       = diff[AW-1:0];
    case (state_r)
      S_INIT: begin
        tbl_we          = 1'b1;
        tbl_waddr       = '0;
        tbl_wdata.reach = 1'b1;
        tbl_wdata.count = '0;
      end
      S_WAIT: begin
        tbl_we = drained;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    coin_count_nxt = cnt_after;
    ovf_nxt        = ovf_after;
    n_nxt          = n_r;
    k_nxt          = k_r;
    target_nxt     = target_r;
    amt_nxt        = amt_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    res_cnt_nxt    = res_cnt_r;
    res_unr_nxt    = res_unr_r;
    res_drop_nxt   = res_drop_r;
    rd1_v_nxt      = (state_r == S_SCAN);
    rd2_v_nxt      = rd1_v_r & (coin_q_r <= amt_r);

    // Fold in the table entry read at the address formed from its registered coin.
    if (rd2_v_r && tbl_q.reach && (!found_r || (tbl_q.count < best_r))) begin
      best_nxt  = tbl_q.count;
      found_nxt = 1'b1;
    end

    case (state_r)
      S_LOAD: begin
        if (in_fire && in_last_item) begin
          coin_count_nxt = '0;
          ovf_nxt        = 1'b0;
          n_nxt          = cnt_after;
          res_drop_nxt   = ovf_after;
          target_nxt     = in_target_amount;
          amt_nxt        = COIN_W'(1);
          res_cnt_nxt    = '0;
          if (in_target_amount == '0) begin
            res_unr_nxt = 1'b0;
            state_nxt   = S_OUT;
          end else if ((32'(in_target_amount) > MAX_AMOUNT) || (cnt_after == '0)) begin
            res_unr_nxt = 1'b1;
            state_nxt   = S_OUT;
          end else begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        k_nxt     = '0;
        found_nxt = 1'b0;
        best_nxt  = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (CW'(k_r) == (n_r - CW'(1))) begin
          k_nxt     = '0;
          state_nxt = S_WAIT;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      S_WAIT: begin
        if (drained) begin
          if (amt_r == target_r) begin
            res_cnt_nxt = found_r ? best_inc : '0;
            res_unr_nxt = ~found_r;
            state_nxt   = S_OUT;
          end else begin
            amt_nxt   = amt_r + COIN_W'(1);
            found_nxt = 1'b0;
            best_nxt  = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      coin_count_r <= '0;
      ovf_r        <= 1'b0;
      rd1_v_r      <= 1'b0;
      rd2_v_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      coin_count_r <= coin_count_nxt;
      ovf_r        <= ovf_nxt;
      rd1_v_r      <= rd1_v_nxt;
      rd2_v_r      <= rd2_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    target_r   <= target_nxt;
    amt_r      <= amt_nxt;
    found_r    <= found_nxt;
    best_r     <= best_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_unr_r  <= res_unr_nxt;
    res_drop_r <= res_drop_nxt;
    if (out_load) begin
      out_cnt_r  <= res_cnt_r;
      out_unr_r  <= res_unr_r;
      out_drop_r <= res_drop_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_min_coins     = out_cnt_r;
  assign out_unreachable   = out_unr_r;
  assign out_coins_dropped = out_drop_r;

endmodule

// ----- rtl/mccd_checker.sv -----
// Port-level checker for min_coin_change_dp, bound to the top level.
// Depends on min_coin_change_dp_defines.svh for the assertion macros.
`include "min_coin_change_dp_defines.svh"

module mccd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_last_item,
  input logic       out_valid,
  input logic       out_stall,
  input logic [9:0] out_min_coins,
  input logic       out_unreachable
);

  // A stalled result transaction stays offered.
  `MCCD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

  // An unreachable answer carries a zero count.
  `MCCD_ASSERT_IMP(a_unr_zero, out_valid && out_unreachable, out_min_coins == 10'd0)

  // Coin loads never stall the next transaction.
  `MCCD_ASSERT_NXT(a_load_ready, in_valid && !in_stall && !in_last_item, !in_stall)

  // Closing the list starts the fill, or goes straight to the answer, and holds off input.
  `MCCD_ASSERT_NXT(a_last_busy, in_valid && !in_stall && in_last_item, in_stall)

endmodule

bind min_coin_change_dp mccd_checker u_mccd_checker (.*);

// ----- test/tb_min_coin_change_dp.sv -----
`timescale 1ns / 100ps
// Self-checking bench for min_coin_change_dp: coin lists in, fewest-coin answers out.
// Depends on mccd_pkg and the min_coin_change_dp RTL; a scoreboard class predicts.
module tb_min_coin_change_dp;

  localparam int COIN_W         = mccd_pkg::COIN_W;
  localparam int COUNT_W        = mccd_pkg::COUNT_W;
  localparam int TB_MAX_AMOUNT  = mccd_pkg::TARGET_MAX;
  localparam int TB_MAX_COINS   = 16;
  localparam int ITEM_GOAL      = 850;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [COUNT_W-1:0] min_coins;
    logic               unreachable;
    logic               coins_dropped;
  } change_answer_t;

  class change_scoreboard;
    logic [COIN_W-1:0] coin_list [TB_MAX_COINS];
    int unsigned       coin_total;
    bit                overflow;
    int unsigned       best [0:TB_MAX_AMOUNT];
    bit                reach [0:TB_MAX_AMOUNT];
    change_answer_t    answers_due [$];
    int unsigned       errors;

    function new();
      coin_total = 0;
      overflow   = 1'b0;
      errors     = 0;
    endfunction

    // Bottom-up table of fewest coins for every amount up to the target.
    function change_answer_t fewest_coins(int unsigned target);
      change_answer_t ans;
      int unsigned    amt, k, low, rest;
      bit             found;
      ans = '0;
      ans.coins_dropped = overflow;
      if (target > TB_MAX_AMOUNT) begin
        ans.unreachable = 1'b1;
        return ans;
      end
      best[0]  = 0;
      reach[0] = 1'b1;
      for (amt = 1; amt <= target; amt++) begin
        found = 1'b0;
        low   = 0;
        for (k = 0; k < coin_total; k++) begin
          if (coin_list[k] <= amt) begin
            rest = amt - coin_list[k];
            if (reach[rest] && (!found || best[rest] < low)) begin
              low   = best[rest];
              found = 1'b1;
            end
          end
        end
        reach[amt] = found;
        best[amt]  = found ? low + 1 : 0;
      end
      if (reach[target]) ans.min_coins = best[target][COUNT_W-1:0];
      else ans.unreachable = 1'b1;
      return ans;
    endfunction

    function void note_input(logic [COIN_W-1:0] value, logic coin_valid,
                             logic [COIN_W-1:0] target, logic last_item);
      if (coin_valid && value != '0) begin
        if (coin_total < TB_MAX_COINS) begin
          coin_list[coin_total] = value;
          coin_total++;
        end else begin
          overflow = 1'b1;
        end
      end
      if (last_item) begin
        answers_due = {answers_due, fewest_coins(target)};
        coin_total = 0;
        overflow   = 1'b0;
      end
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [COUNT_W-1:0] min_coins, logic unreachable,
                      logic coins_dropped);
      change_answer_t due;
      if (answers_due.size() == 0) begin
        report_mismatch("answer with none pending");
        return;
      end
      due = answers_due.pop_front();
      if (min_coins !== due.min_coins)
        report_mismatch($sformatf("min_coins %0d, want %0d", min_coins, due.min_coins));
      if (unreachable !== due.unreachable)
        report_mismatch($sformatf("unreachable %b, want %b", unreachable, due.unreachable));
      if (coins_dropped !== due.coins_dropped)
        report_mismatch($sformatf("coins_dropped %b, want %b", coins_dropped,
                                  due.coins_dropped));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [COIN_W-1:0]  in_coin_value;
  logic               in_coin_valid;
  logic [COIN_W-1:0]  in_target_amount;
  logic               in_last_item;
  logic               out_valid;
  logic               out_stall;
  logic [COUNT_W-1:0] out_min_coins;
  logic               out_unreachable;
  logic               out_coins_dropped;

  change_scoreboard sb = new();
  int unsigned      items_sent;
  int unsigned      quiet_cycles;
  bit               idle_enable;
  bit               hold_req;

  min_coin_change_dp #(
    .MAX_AMOUNT (TB_MAX_AMOUNT),
    .MAX_COINS  (TB_MAX_COINS)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_coin_value     (in_coin_value),
    .in_coin_valid     (in_coin_valid),
    .in_target_amount  (in_target_amount),
    .in_last_item      (in_last_item),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_min_coins     (out_min_coins),
    .out_unreachable   (out_unreachable),
    .out_coins_dropped (out_coins_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Monitor both channels on the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_input(in_coin_value, in_coin_valid, in_target_amount, in_last_item);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_min_coins, out_unreachable, out_coins_dropped);
  end

  // Abort when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("min_coin_change_dp regression: fail");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic [COIN_W-1:0] value, input logic coin_valid,
                           input logic [COIN_W-1:0] target, input logic last_item);
    int unsigned gap;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_coin_value    <= value;
    in_coin_valid    <= coin_valid;
    in_target_amount <= target;
    in_last_item     <= last_item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and hold until every pending answer has been taken.
  task automatic wait_for_answers();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.answers_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [COIN_W-1:0] pick_coin();
    if ($urandom_range(0, 5) == 0) return COIN_W'($urandom_range(0, 1023));
    return COIN_W'($urandom_range(1, 12));
  endfunction

  // One coin list with its closing transaction; noise items mixed in.
  task automatic send_coin_list(input bit small_only);
    int unsigned       n_coins, sel, i;
    logic [COIN_W-1:0] target;
    sel = $urandom_range(0, 19);
    if (sel < 12) n_coins = $urandom_range(1, 4);
    else if (sel < 17) n_coins = $urandom_range(5, 16);
    else if (sel < 19) n_coins = $urandom_range(17, 20);
    else n_coins = 0;
    if (small_only) begin
      target = COIN_W'($urandom_range(0, 12));
    end else if ($urandom_range(0, 39) == 0) begin
      // Keep long fills cheap: few coins for a large target.
      target = COIN_W'($urandom_range(0, 1023));
      if (n_coins > 3) n_coins = 3;
    end else begin
      target = COIN_W'($urandom_range(0, 48));
    end
    for (i = 0; i < n_coins; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_item(COIN_W'($urandom_range(0, 1023)), 1'b0,
                  COIN_W'($urandom_range(0, 1023)), 1'b0);
      else if ($urandom_range(0, 15) == 0)
        send_item('0, 1'b1, COIN_W'($urandom_range(0, 1023)), 1'b0);
      send_item(pick_coin(), 1'b1, COIN_W'($urandom_range(0, 1023)), 1'b0);
    end
    send_item(pick_coin(), 1'($urandom_range(0, 1)), target, 1'b1);
  endtask

  initial begin
    logic [COIN_W-1:0] full_set [TB_MAX_COINS];
    bit                hold_done, pause_done;
    int unsigned       i;
    full_set = '{10'd1023, 10'd1, 10'd2, 10'd4, 10'd8, 10'd16, 10'd32, 10'd64,
                 10'd128, 10'd256, 10'd512, 10'd3, 10'd5, 10'd7, 10'd100, 10'd700};
    hold_done        = 1'b0;
    pause_done       = 1'b0;
    items_sent       = 0;
    idle_enable      = 1'b1;
    hold_req         = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_coin_value    = '0;
    in_coin_valid    = 1'b0;
    in_target_amount = '0;
    in_last_item     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty list: zero target reachable, nonzero target not.
    send_item('0, 1'b0, '0, 1'b1);
    send_item('0, 1'b0, 10'd1023, 1'b1);
    // Zero coin and coin without its valid are ignored; coin on the last item counts.
    send_item('0, 1'b1, 10'd5, 1'b0);
    send_item(10'd7, 1'b0, 10'd5, 1'b0);
    send_item(10'd3, 1'b1, 10'd6, 1'b1);
    // Target that the coins cannot make.
    send_item(10'd2, 1'b1, '0, 1'b0);
    send_item('0, 1'b0, 10'd3, 1'b1);
    // Largest count: the top target from unit coins alone.
    send_item(10'd1, 1'b1, 10'd1023, 1'b1);
    // Fill the coin store, then drop one more on the last transaction.
    for (i = 0; i < TB_MAX_COINS; i++) send_item(full_set[i], 1'b1, '0, 1'b0);
    send_item(10'd9, 1'b1, 10'd1023, 1'b1);

    while (items_sent < ITEM_GOAL) begin
      if (!hold_done && items_sent >= 300) begin
        // Keep offering short lists while the receiver holds off.
        hold_done = 1'b1;
        hold_req  = 1'b1;
        while (hold_req) send_coin_list(1'b1);
      end
      if (!pause_done && items_sent >= 500) begin
        pause_done = 1'b1;
        wait_for_answers();
      end
      if (items_sent >= 720) idle_enable = 1'b0;
      send_coin_list(1'b0);
    end

    wait_for_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("min_coin_change_dp regression: pass");
    end else begin
      $display("min_coin_change_dp regression: fail");
    end
    $finish;
  end

endmodule
